// File: hw/rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int CHANNEL_BITS_DEF = 8;
	localparam int HUE_W            = 9;
	// Holds a sector fraction numerator or its complement, 0..60
	localparam int FRAC_W           = 6;
	localparam int STAGES           = 6;
	localparam int NUM_SECTORS      = 6;
	localparam int DEG_FULL         = 360;
	localparam int DEG_SECTOR       = 60;

	localparam logic [FRAC_W-1:0] FRAC_FULL = FRAC_W'(DEG_SECTOR);

	typedef enum logic [2:0] {
		SECTOR_0,
		SECTOR_1,
		SECTOR_2,
		SECTOR_3,
		SECTOR_4,
		SECTOR_5
	} sector_t;

	typedef struct packed {
		logic              en;
		logic [STAGES:1]   vld;
	} lane_ctl_t;

endpackage

// File: hw/rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to RGB color converter.
// ----------------------------------------------------------------------------
// Input channel: hue (degrees), saturation, brightness with hsv_valid and
// hsv_stall. Output channel: red, green, blue with rgb_valid and rgb_stall.
// A transaction completes on a clock edge with valid high and stall low.
// Hue 360..511 wraps by one turn; saturation and brightness use full scale
// 2^CHANNEL_BITS-1 as 1.0. Results are floored, exact to the last bit.
// From input transaction to rgb_valid a color passes a hue split stage,
// five arithmetic stages (multiply, divide-by-60, multiply, divide-by-60,
// divide by full scale) and the output register. Unless the output stalls,
// one color is accepted every cycle; throughput is one transaction per clock.
// When the receiver stalls a valid result, the whole pipeline holds and
// hsv_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              hsv_valid,
	output logic                              hsv_stall,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
	input  logic [CHANNEL_BITS-1:0]           saturation,
	input  logic [CHANNEL_BITS-1:0]           brightness,
	output logic                              rgb_valid,
	input  logic                              rgb_stall,
	output logic [CHANNEL_BITS-1:0]           red,
	output logic [CHANNEL_BITS-1:0]           green,
	output logic [CHANNEL_BITS-1:0]           blue
);

	localparam int N  = CHANNEL_BITS;
	localparam int HW = hsv2rgb_pkg::HUE_W;
	localparam int FW = hsv2rgb_pkg::FRAC_W;
	localparam int ST = hsv2rgb_pkg::STAGES;

	logic                         en;
	logic [ST:1]                  stage_vld_q;
	logic                         rgb_valid_q;
	hsv2rgb_pkg::lane_ctl_t       lane_ctl;

	logic [HW-1:0]                hue_w;
	logic [HW-1:0]                base_c;
	hsv2rgb_pkg::sector_t         sec_c;
	logic [FW-1:0]                rem_c;

	logic [N-1:0]                 sat_s1;
	logic [N-1:0]                 val_s1;
	logic [FW-1:0]                rem_s1;
	hsv2rgb_pkg::sector_t         sec_s1, sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic [N-1:0]                 val_s2, val_s3, val_s4, val_s5, val_s6;

	logic [N-1:0]                 p_s6, q_s6, t_s6;
	logic [N-1:0]                 red_c, green_c, blue_c;
	logic [N-1:0]                 red_q, green_q, blue_q;

	// whole pipeline advances unless a finished result is held
	assign en        = !(rgb_valid_q && rgb_stall);
	assign hsv_stall = !en;
	assign lane_ctl  = '{en: en, vld: stage_vld_q};

	always_comb begin
		hue_w = (hue >= HW'(hsv2rgb_pkg::DEG_FULL)) ? hue - HW'(hsv2rgb_pkg::DEG_FULL) : hue;
		sec_c  = hsv2rgb_pkg::SECTOR_0;
		base_c = '0;
		for (int i = 1; i < hsv2rgb_pkg::NUM_SECTORS; i++) begin
			if (hue_w >= HW'(i * hsv2rgb_pkg::DEG_SECTOR)) begin
				sec_c  = hsv2rgb_pkg::sector_t'(i);
				base_c = HW'(i * hsv2rgb_pkg::DEG_SECTOR);
			end
		end
		rem_c = FW'(hue_w - base_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			rgb_valid_q <= 1'b0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[ST-1:1], hsv_valid};
			rgb_valid_q <= stage_vld_q[ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s1  <= saturation;
			val_s1  <= brightness;
			rem_s1  <= rem_c;
			sec_s1  <= sec_c;
			sec_s2  <= sec_s1;
			sec_s3  <= sec_s2;
			sec_s4  <= sec_s3;
			sec_s5  <= sec_s4;
			sec_s6  <= sec_s5;
			val_s2  <= val_s1;
			val_s3  <= val_s2;
			val_s4  <= val_s3;
			val_s5  <= val_s4;
			val_s6  <= val_s5;
			red_q   <= red_c;
			green_q <= green_c;
			blue_q  <= blue_c;
		end
	end

	// p = v(1-s), q = v(1-s*f), t = v(1-s(1-f))
	hsv2rgb_lane #(.CHANNEL_BITS(N)) u_lane_p (
		.clk(clk), .ctl(lane_ctl), .sat(sat_s1), .val(val_s1),
		.k(hsv2rgb_pkg::FRAC_FULL), .res(p_s6)
	);

	hsv2rgb_lane #(.CHANNEL_BITS(N)) u_lane_q (
		.clk(clk), .ctl(lane_ctl), .sat(sat_s1), .val(val_s1),
		.k(rem_s1), .res(q_s6)
	);

	hsv2rgb_lane #(.CHANNEL_BITS(N)) u_lane_t (
		.clk(clk), .ctl(lane_ctl), .sat(sat_s1), .val(val_s1),
		.k(hsv2rgb_pkg::FRAC_FULL - rem_s1), .res(t_s6)
	);

	always_comb begin
		unique case (sec_s6)
			hsv2rgb_pkg::SECTOR_0: begin
				red_c = val_s6; green_c = t_s6;   blue_c = p_s6;
			end
			hsv2rgb_pkg::SECTOR_1: begin
				red_c = q_s6;   green_c = val_s6; blue_c = p_s6;
			end
			hsv2rgb_pkg::SECTOR_2: begin
				red_c = p_s6;   green_c = val_s6; blue_c = t_s6;
			end
			hsv2rgb_pkg::SECTOR_3: begin
				red_c = p_s6;   green_c = q_s6;   blue_c = val_s6;
			end
			hsv2rgb_pkg::SECTOR_4: begin
				red_c = t_s6;   green_c = p_s6;   blue_c = val_s6;
			end
			default: begin
				red_c = val_s6; green_c = p_s6;   blue_c = q_s6;
			end
		endcase
	end

	assign rgb_valid = rgb_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

`ifndef SYNTHESIS
	// a held pipeline keeps every in-flight transaction in place
	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stage_vld_q))
		else $error("pipeline valid bits moved while stalled");

	// last arithmetic stage always reaches the output register
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && stage_vld_q[ST]) |=> rgb_valid)
		else $error("transaction lost at output stage");
`endif

endmodule

// File: hw/rtl/hsv2rgb_div60.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div60
// Constant divide by 60: drop two bits, then reciprocal multiply for /15.
// ----------------------------------------------------------------------------
module hsv2rgb_div60 #(
	parameter int W  = 14,
	parameter int OW = 8
) (
	input  logic [W-1:0]  x,
	output logic [OW-1:0] q
);

	localparam int ZW = W - 2;
	localparam int K  = ZW + 4;
	localparam int RW = K - 3;
	localparam int PW = ZW + RW;
	// ceil(2^K / 15); error term stays under 2^(K-ZW), so the quotient is exact
	localparam logic [RW-1:0] RECIP = RW'(((64'd1 << K) + 64'd14) / 64'd15);

	logic [ZW-1:0] z;
	logic [PW-1:0] prod;

	assign z    = x[W-1:2];
	assign prod = PW'(z) * PW'(RECIP);
	assign q    = prod[K +: OW];

endmodule

// File: hw/rtl/hsv2rgb_divm.sv
// ----------------------------------------------------------------------------
// hsv2rgb_divm
// Divide by full scale 2^N-1 for values up to (2^N-1)^2, with one correction.
// ----------------------------------------------------------------------------
module hsv2rgb_divm #(
	parameter int N = 8
) (
	input  logic [2*N-1:0] y,
	output logic [N-1:0]   q
);

	localparam logic [N-1:0] CHAN_MAX = '1;

	logic [2*N:0] sum;
	logic [N:0]   est;
	logic [2*N:0] rem;
	logic         fix;

	// y/(2^N-1) ~ (y + y/2^N) / 2^N, low by at most one
	assign sum = {1'b0, y} + (2*N+1)'(y >> N);
	assign est = sum[2*N:N];
	assign rem = {1'b0, y} + (2*N+1)'(est) - ((2*N+1)'(est) << N);
	assign fix = (rem >= (2*N+1)'(CHAN_MAX));
	assign q   = est[N-1:0] + N'(fix);

endmodule

// File: hw/rtl/hsv2rgb_lane.sv
// ----------------------------------------------------------------------------
// hsv2rgb_lane
// One channel term: floor(v * (60M - s*k) / (60M)), five register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_lane #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                 clk,
	input  hsv2rgb_pkg::lane_ctl_t               ctl,
	input  logic [CHANNEL_BITS-1:0]              sat,
	input  logic [CHANNEL_BITS-1:0]              val,
	input  logic [hsv2rgb_pkg::FRAC_W-1:0]       k,
	output logic [CHANNEL_BITS-1:0]              res
);

	localparam int N  = CHANNEL_BITS;
	localparam int SW = N + hsv2rgb_pkg::FRAC_W;
	localparam int YW = 2 * N;
	localparam logic [N-1:0] CHAN_MAX = '1;

	logic [SW-1:0]                    sr_s2;
	logic [N-1:0]                     val_s2;
	logic [N-1:0]                     a_s3;
	logic [SW-1:0]                    sr_s3;
	logic [N-1:0]                     val_s3;
	logic [YW-1:0]                    u_s4;
	logic [SW-1:0]                    w_s4;
	logic [N-1:0]                     c_s5;
	logic [YW-1:0]                    u_s5;
	logic [N-1:0]                     res_s6;

	logic [N-1:0]                     a_c;
	logic [SW-1:0]                    a60_c;
	logic [hsv2rgb_pkg::FRAC_W-1:0]   b_c;
	logic [SW-1:0]                    wp_c;
	logic [N-1:0]                     c_c;
	logic [YW-1:0]                    y_c;
	logic [N-1:0]                     q_c;

	// s*k = 60a + b; then floor(v(60(M-a) - b) / 60) = v(M-a) - ceil(vb/60)
	hsv2rgb_div60 #(.W(SW), .OW(N)) u_div_a (.x(sr_s2), .q(a_c));

	assign a60_c = (SW'(a_s3) << 6) - (SW'(a_s3) << 2);
	assign b_c   = hsv2rgb_pkg::FRAC_W'(sr_s3 - a60_c);
	assign wp_c  = w_s4 + SW'(hsv2rgb_pkg::DEG_SECTOR - 1);

	hsv2rgb_div60 #(.W(SW), .OW(N)) u_div_c (.x(wp_c), .q(c_c));

	assign y_c = u_s5 - YW'(c_s5);

	hsv2rgb_divm #(.N(N)) u_divm (.y(y_c), .q(q_c));

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sr_s2  <= SW'(sat) * SW'(k);
			val_s2 <= val;
			a_s3   <= a_c;
			sr_s3  <= sr_s2;
			val_s3 <= val_s2;
			u_s4   <= YW'(val_s3) * YW'(CHAN_MAX - a_s3);
			w_s4   <= SW'(val_s3) * SW'(b_c);
			c_s5   <= c_c;
			u_s5   <= u_s4;
			res_s6 <= q_c;
		end
	end

	assign res = res_s6;

`ifndef SYNTHESIS
	// sector remainder from the divider must land in 0..59
	a_rem_range: assert property (@(posedge clk)
		ctl.vld[3] |-> (sr_s3 >= a60_c) && ((sr_s3 - a60_c) < SW'(hsv2rgb_pkg::FRAC_FULL)))
		else $error("div60 remainder out of range");

	// rounded-up correction never exceeds the main product
	a_no_underflow: assert property (@(posedge clk)
		ctl.vld[5] |-> (YW'(c_s5) <= u_s5))
		else $error("lane difference underflow");
`endif

endmodule

// File: bench/rgb_color_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_color_checker
// Watches both channels of the HSV to RGB converter. Every color accepted at
// the input is converted here with exact integer arithmetic and queued; every
// color leaving the output is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rgb_color_checker #(
	parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hsv_valid,
	input  logic                          hsv_stall,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  logic [CHANNEL_BITS-1:0]       saturation,
	input  logic [CHANNEL_BITS-1:0]       brightness,
	input  logic                          rgb_valid,
	input  logic                          rgb_stall,
	input  logic [CHANNEL_BITS-1:0]       red,
	input  logic [CHANNEL_BITS-1:0]       green,
	input  logic [CHANNEL_BITS-1:0]       blue,
	output int                            mismatches,
	output int                            colors_owed
);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] r;
		logic [CHANNEL_BITS-1:0] g;
		logic [CHANNEL_BITS-1:0] b;
	} color_t;

	color_t owed_colors[$];

	function automatic color_t convert_hsv(logic [hsv2rgb_pkg::HUE_W-1:0] h,
			logic [CHANNEL_BITS-1:0] s, logic [CHANNEL_BITS-1:0] v);
		longint unsigned full, den, deg, rem, sv, vv, p, q, t, r, g, b;
		hsv2rgb_pkg::sector_t sec;
		color_t c;
		full = (64'd1 << CHANNEL_BITS) - 1;
		den  = hsv2rgb_pkg::DEG_SECTOR * full;
		sv   = s;
		vv   = v;
		deg  = h;
		// 360..511 wraps by one full turn
		if (deg >= hsv2rgb_pkg::DEG_FULL)
			deg = deg - hsv2rgb_pkg::DEG_FULL;
		sec = hsv2rgb_pkg::sector_t'(3'(deg / hsv2rgb_pkg::DEG_SECTOR));
		rem = deg % hsv2rgb_pkg::DEG_SECTOR;
		p = (vv * (full - sv)) / full;
		q = (vv * (den - sv * rem)) / den;
		t = (vv * (den - sv * (hsv2rgb_pkg::DEG_SECTOR - rem))) / den;
		case (sec)
			hsv2rgb_pkg::SECTOR_0: begin r = vv; g = t;  b = p;  end
			hsv2rgb_pkg::SECTOR_1: begin r = q;  g = vv; b = p;  end
			hsv2rgb_pkg::SECTOR_2: begin r = p;  g = vv; b = t;  end
			hsv2rgb_pkg::SECTOR_3: begin r = p;  g = q;  b = vv; end
			hsv2rgb_pkg::SECTOR_4: begin r = t;  g = p;  b = vv; end
			default: begin r = vv; g = p;  b = q;  end
		endcase
		c.r = r[CHANNEL_BITS-1:0];
		c.g = g[CHANNEL_BITS-1:0];
		c.b = b[CHANNEL_BITS-1:0];
		return c;
	endfunction

	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			if (hsv_valid && !hsv_stall)
				owed_colors.push_back(convert_hsv(hue, saturation, brightness));
			if (rgb_valid && !rgb_stall) begin
				if (owed_colors.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("%0t: unexpected color r=%0d g=%0d b=%0d",
							$time, red, green, blue);
				end else begin
					want = owed_colors.pop_front();
					if (red !== want.r || green !== want.g || blue !== want.b) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, %s",
								$time, want.r, want.g, want.b,
								$sformatf("got r=%0d g=%0d b=%0d", red, green, blue));
					end
				end
			end
			colors_owed = owed_colors.size();
		end
	end

endmodule

// File: bench/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Drives HSV colors into the converter: a directed set covering every sector
// boundary, hue wrap and channel extremes, then random phases with random
// gaps and stalls on both sides and a long output hold-off that backs up the
// pipeline. The checker beside the block reports mismatches.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

	localparam int CB           = hsv2rgb_pkg::CHANNEL_BITS_DEF;
	localparam int HUE_W        = hsv2rgb_pkg::HUE_W;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 200;
	localparam int LONG_HOLD    = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic          clk;
	logic          arst_n;
	logic          hsv_valid;
	logic          hsv_stall;
	logic [HUE_W-1:0] hue;
	logic [CB-1:0] saturation;
	logic [CB-1:0] brightness;
	logic          rgb_valid;
	logic          rgb_stall;
	logic [CB-1:0] red;
	logic [CB-1:0] green;
	logic [CB-1:0] blue;

	int  mismatches;
	int  colors_owed;
	int  idle_cycles;
	bit  src_back_to_back;
	bit  sink_never_stalls;
	int  hold_requests;

	hsv_to_rgb_converter #(.CHANNEL_BITS(CB)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	rgb_color_checker #(.CHANNEL_BITS(CB)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.rgb_valid   (rgb_valid),
		.rgb_stall   (rgb_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.mismatches  (mismatches),
		.colors_owed (colors_owed)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with hsv_valid still high so a back-to-back color needs no toggle.
	task automatic send_color(input logic [HUE_W-1:0] h, input logic [CB-1:0] s,
			input logic [CB-1:0] v);
		int gap;
		gap = src_back_to_back ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			hsv_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hue        <= h;
		saturation <= s;
		brightness <= v;
		hsv_valid  <= 1'b1;
		do @(posedge clk); while (hsv_stall);
		@(negedge clk);
	endtask

	function automatic logic [CB-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CB'($urandom_range(0, (1 << CB) - 1));
		endcase
	endfunction

	// Receiver: random stall before each result, or one long hold-off on request
	initial begin
		int hold;
		int holds_done;
		holds_done = 0;
		rgb_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (holds_done < hold_requests) begin
				hold = LONG_HOLD;
				holds_done = holds_done + 1;
			end else begin
				hold = sink_never_stalls ? 0 : $urandom_range(0, 10);
			end
			if (hold > 0) begin
				rgb_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rgb_stall <= 1'b0;
			do @(posedge clk); while (!rgb_valid);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		hsv_valid         = 1'b0;
		hue               = '0;
		saturation        = '0;
		brightness        = '0;
		src_back_to_back  = 1'b0;
		sink_never_stalls = 1'b0;
		hold_requests     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sector boundaries, hue wrap, channel extremes
		send_color(9'd0,   8'd0,   8'd0);
		send_color(9'd0,   8'd255, 8'd255);
		send_color(9'd59,  8'd255, 8'd255);
		send_color(9'd60,  8'd255, 8'd255);
		send_color(9'd119, 8'd255, 8'd255);
		send_color(9'd120, 8'd255, 8'd255);
		send_color(9'd179, 8'd255, 8'd255);
		send_color(9'd180, 8'd255, 8'd255);
		send_color(9'd239, 8'd255, 8'd255);
		send_color(9'd240, 8'd255, 8'd255);
		send_color(9'd299, 8'd255, 8'd255);
		send_color(9'd300, 8'd255, 8'd255);
		send_color(9'd359, 8'd255, 8'd255);
		send_color(9'd360, 8'd255, 8'd255);
		send_color(9'd511, 8'd255, 8'd255);
		send_color(9'd361, 8'd128, 8'd200);
		send_color(9'd30,  8'd0,   8'd255);
		send_color(9'd90,  8'd255, 8'd0);
		send_color(9'd150, 8'd1,   8'd254);
		send_color(9'd210, 8'd170, 8'd85);
		send_color(9'd270, 8'd255, 8'd1);
		send_color(9'd330, 8'd85,  8'd170);
		send_color(9'd256, 8'd127, 8'd128);

		for (int ph = 0; ph < PHASES; ph++) begin
			src_back_to_back  = (ph % 3 == 1) || (ph == 3) || (ph == 5);
			sink_never_stalls = (ph % 4 == 2);
			if (ph == 3 || ph == 5)
				hold_requests = hold_requests + 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				logic [HUE_W-1:0] h;
				h = ($urandom_range(0, 9) == 0) ? HUE_W'($urandom_range(360, 511))
				                                : HUE_W'($urandom_range(0, 359));
				send_color(h, pick_level(), pick_level());
			end
		end
		hsv_valid <= 1'b0;

		while (colors_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
